// ===== hw/rtl/dnt_pkg.sv =====
package dnt_pkg;

   // Request opcodes.
   localparam logic [1:0] OP_FIND   = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   // Response status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_DUPLICATE = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // Field widths on the streams.
   localparam int OPCODE_W = 2;
   localparam int KEY_W    = 64;
   localparam int SECIN_W  = 10;
   localparam int STATUS_W = 2;
   localparam int FSEC_W   = 10;
   localparam int SLOT_W   = 6;

   // Request tdata layout.
   localparam int REQ_OP_LSB  = 0;
   localparam int REQ_KEY_LSB = REQ_OP_LSB + OPCODE_W;
   localparam int REQ_SEC_LSB = REQ_KEY_LSB + KEY_W;
   localparam int REQ_USED_W  = REQ_SEC_LSB + SECIN_W;
   localparam int REQ_W       = ((REQ_USED_W + 7) / 8) * 8;

   // Response tdata layout.
   localparam int RSP_ST_LSB   = 0;
   localparam int RSP_SEC_LSB  = RSP_ST_LSB + STATUS_W;
   localparam int RSP_SLOT_LSB = RSP_SEC_LSB + FSEC_W;
   localparam int RSP_USED_W   = RSP_SLOT_LSB + SLOT_W;
   localparam int RSP_W        = ((RSP_USED_W + 7) / 8) * 8;

   typedef logic [REQ_W-1:0] req_data_type;
   typedef logic [RSP_W-1:0] rsp_data_type;

endpackage

// ===== hw/rtl/directory_name_table_core.sv =====
// Channel | Direction | Ports                                   | Transfer carries
// req     | in        | req_tvalid, req_tready, req_tdata[79:0] | opcode, name_key, sector
// rsp     | out       | rsp_tvalid, rsp_tready, rsp_tdata[23:0] | status, found_sector, slot_index
//
// Each request scans the whole table before its result is given:
// every slot is read once from the single read port of the slot memory, one per cycle.
// Requests are served one at a time; the next one is taken while the result waits.
// After reset a clearing pass marks every slot free; req_tready is low during it.
// A result that is not taken holds the block at the end of the following request.
module directory_name_table_core #(
   parameter int ENTRIES     = 64,
   parameter int NAME_BITS   = 64,
   parameter int SECTOR_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [1:0] opcode, [65:2] name_key, [75:66] sector, [79:76] zero
   input  dnt_pkg::req_data_type req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] status, [11:2] found_sector, [17:12] slot_index, [23:18] zero
   output dnt_pkg::rsp_data_type rsp_tdata
);
   import dnt_pkg::*;

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int MW = 1 + SECTOR_BITS + NAME_BITS;
   localparam logic [KEY_W-1:0] NAME_MASK = {KEY_W{1'b1}} >> (KEY_W - NAME_BITS);
   localparam logic [CW-1:0] LAST_CNT = CW'(ENTRIES - 1);
   localparam logic [CW-1:0] END_CNT  = CW'(ENTRIES);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;

   logic [1:0]             op_ff;
   logic [NAME_BITS-1:0]   key_ff;
   logic [SECTOR_BITS-1:0] sec_ff;

   // Slot memory: used mark, sector, name.
   logic [MW-1:0]          slot_mem [ENTRIES];
   logic [MW-1:0]          rd_data_ff;
   logic                   rd_vld_ff;
   logic [AW-1:0]          rd_idx_ff;

   logic                   match_ff;
   logic [AW-1:0]          match_idx_ff;
   logic [SECTOR_BITS-1:0] match_sec_ff;
   logic                   free_ff;
   logic [AW-1:0]          free_idx_ff;

   logic                   rsp_tvalid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff, res_status;
   logic [FSEC_W-1:0]      rsp_fsec_ff, res_fsec;
   logic [SLOT_W-1:0]      rsp_slot_ff, res_slot;

   logic                   req_xfer, issue, finish;
   logic                   wr_en, res_write;
   logic [AW-1:0]          wr_addr, res_addr;
   logic [MW-1:0]          wr_data, res_data;

   logic [KEY_W-1:0]       key_raw, key_norm;
   logic [31:0]            sec_wide, fsec_wide, slot_wide;

   logic                   rd_used;
   logic [SECTOR_BITS-1:0] rd_sec;
   logic [NAME_BITS-1:0]   rd_name;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign issue      = (state_ff == S_SCAN) && (cnt_ff != END_CNT);
   assign finish     = (state_ff == S_DONE) && (!rsp_tvalid_ff || rsp_tready);

   // A name ends at its first zero byte; that byte and all above count as zero.
   always_comb begin
      logic live;
      key_raw  = req_tdata[REQ_KEY_LSB +: KEY_W] & NAME_MASK;
      key_norm = '0;
      live     = 1'b1;
      for (int b = 0; b < KEY_W / 8; b++) begin
         if (key_raw[8*b +: 8] == 8'd0) begin
            live = 1'b0;
         end
         if (live) begin
            key_norm[8*b +: 8] = key_raw[8*b +: 8];
         end
      end
   end

   assign sec_wide = 32'(req_tdata[REQ_SEC_LSB +: SECIN_W]);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == LAST_CNT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cnt_in = '0;
            if (req_xfer) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue) begin
               cnt_in = cnt_ff + CW'(1);
            end else if (!rd_vld_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff  <= req_tdata[REQ_OP_LSB +: OPCODE_W];
         key_ff <= key_norm[NAME_BITS-1:0];
         sec_ff <= sec_wide[SECTOR_BITS-1:0];
      end
   end

   // Memory: one read port during the scan, one write port for clearing and updates.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[cnt_ff[AW-1:0]];
      rd_idx_ff  <= cnt_ff[AW-1:0];
   end

   assign rd_used = rd_data_ff[MW-1];
   assign rd_sec  = rd_data_ff[NAME_BITS +: SECTOR_BITS];
   assign rd_name = rd_data_ff[NAME_BITS-1:0];

   // The scan runs in ascending slot order, so the first hit of each kind is the lowest.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         match_ff <= 1'b0;
         free_ff  <= 1'b0;
      end else if (rd_vld_ff) begin
         if (rd_used && (rd_name == key_ff) && !match_ff) begin
            match_ff     <= 1'b1;
            match_idx_ff <= rd_idx_ff;
            match_sec_ff <= rd_sec;
         end
         if (!rd_used && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
      end
   end

   always_comb begin
      res_status = ST_NOT_FOUND;
      res_write  = 1'b0;
      res_addr   = match_idx_ff;
      res_data   = {1'b0, sec_ff, key_ff};
      fsec_wide  = '0;
      slot_wide  = '0;
      unique case (op_ff)
         OP_FIND: begin
            if (match_ff) begin
               res_status = ST_OK;
               fsec_wide  = 32'(match_sec_ff);
               slot_wide  = 32'(match_idx_ff);
            end
         end
         OP_ADD: begin
            if (match_ff) begin
               res_status = ST_DUPLICATE;
            end else if (free_ff) begin
               res_status = ST_OK;
               res_write  = 1'b1;
               res_addr   = free_idx_ff;
               res_data   = {1'b1, sec_ff, key_ff};
               slot_wide  = 32'(free_idx_ff);
            end else begin
               res_status = ST_FULL;
            end
         end
         OP_REMOVE: begin
            if (match_ff) begin
               res_status = ST_OK;
               res_write  = 1'b1;
               slot_wide  = 32'(match_idx_ff);
            end
         end
         default: begin
            res_status = ST_NOT_FOUND;
         end
      endcase
      res_fsec = fsec_wide[FSEC_W-1:0];
      res_slot = slot_wide[SLOT_W-1:0];
   end

   always_comb begin
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff[AW-1:0];
         wr_data = '0;
      end else begin
         wr_en   = finish && res_write;
         wr_addr = res_addr;
         wr_data = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (finish) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_status_ff <= res_status;
         rsp_fsec_ff   <= res_fsec;
         rsp_slot_ff   <= res_slot;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(RSP_W - RSP_USED_W)'(0), rsp_slot_ff, rsp_fsec_ff, rsp_status_ff};

endmodule

// ===== hw/rtl/dnt_checker.sv =====
module dnt_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input dnt_pkg::rsp_data_type rsp_tdata
);
   import dnt_pkg::*;

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Failed requests report neither a sector nor a slot.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[RSP_ST_LSB +: STATUS_W] != ST_OK)
      |-> (rsp_tdata[RSP_SEC_LSB +: FSEC_W + SLOT_W] == '0))
      else $error("failed request carries sector or slot");

   // The clearing pass keeps requests out right after reset.
   a_clear_busy: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during clearing pass");

   // One request at a time: the scan follows every accepted request.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken during a scan");

endmodule

bind directory_name_table_core dnt_checker u_dnt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/sv/directory_name_table_core_test.sv =====
`timescale 1ns / 1ps

module directory_name_table_core_test;
   import dnt_pkg::*;

   localparam int ENTRIES = 64;
   localparam int POOL_SIZE = 80;
   localparam int RANDOM_ITEMS = 1750;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  opcode;
      logic [63:0] name_key;
      logic [9:0]  sector;
      int          gap_after;
      bit          wait_empty;
   } dir_request_type;

   typedef struct packed {
      logic [1:0] status;
      logic [9:0] found_sector;
      logic [5:0] slot_index;
   } dir_answer_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   req_data_type req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   rsp_data_type rsp_tdata;

   directory_name_table_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Shadow copy of the directory, updated in transfer order.
   bit          dir_used [ENTRIES];
   logic [63:0] dir_key [ENTRIES];
   logic [9:0]  dir_sector [ENTRIES];

   dir_request_type dir_requests[$];
   dir_answer_type  dir_answers[$];
   logic [63:0]     name_pool [POOL_SIZE];

   int faults = 0;
   int replies_seen = 0;
   int hold_left = 0;
   int cycle_no = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("Test completed with failures");
      $finish;
   end

   task automatic flag_error(string msg);
      faults++;
      // Keep the log bounded when the block is badly broken.
      if (faults <= 100) $display("ERROR %0t: %s", $time, msg);
   endtask

   // A name ends at its first zero byte; everything above it reads as zero.
   function automatic logic [63:0] trim_name(logic [63:0] raw);
      logic [63:0] kept;
      kept = '0;
      for (int b = 0; b < 8; b++) begin
         if (raw[8*b +: 8] == 8'h00) break;
         kept[8*b +: 8] = raw[8*b +: 8];
      end
      return kept;
   endfunction

   function automatic dir_answer_type serve_request(dir_request_type rq);
      dir_answer_type ans;
      logic [63:0]    name;
      int             hit;
      ans = '{status: ST_NOT_FOUND, found_sector: '0, slot_index: '0};
      name = trim_name(rq.name_key);
      hit = -1;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (dir_used[i] && dir_key[i] == name) hit = i;
      end
      case (rq.opcode)
         OP_FIND: begin
            if (hit >= 0) begin
               ans.status = ST_OK;
               ans.found_sector = dir_sector[hit];
               ans.slot_index = 6'(hit);
            end
         end
         OP_ADD: begin
            if (hit >= 0) begin
               ans.status = ST_DUPLICATE;
            end else begin
               ans.status = ST_FULL;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (!dir_used[i]) begin
                     dir_used[i] = 1'b1;
                     dir_key[i] = name;
                     dir_sector[i] = rq.sector;
                     ans.status = ST_OK;
                     ans.slot_index = 6'(i);
                     break;
                  end
               end
            end
         end
         OP_REMOVE: begin
            if (hit >= 0) begin
               dir_used[hit] = 1'b0;
               ans.status = ST_OK;
               ans.slot_index = 6'(hit);
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   // Mostly names from a small pool so that finds and removes hit, sometimes
   // with junk after the terminating zero byte, sometimes a fully random key.
   function automatic logic [63:0] pick_name();
      logic [63:0] k;
      int          roll;
      int          len;
      roll = $urandom_range(0, 99);
      if (roll < 8) return {$urandom, $urandom};
      k = name_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (roll < 40) begin
         len = 0;
         while (len < 8 && k[8*len +: 8] != 8'h00) len++;
         for (int b = len + 1; b < 8; b++) k[8*b +: 8] = 8'($urandom);
      end
      return k;
   endfunction

   task automatic queue_request(logic [1:0] op, logic [63:0] key, logic [9:0] sec,
                                int gap, bit wait_empty);
      dir_request_type rq;
      rq.opcode = op;
      rq.name_key = key;
      rq.sector = sec;
      rq.gap_after = gap;
      rq.wait_empty = wait_empty;
      dir_requests.push_back(rq);
   endtask

   // Request driver.
   dir_request_type cur_req;
   int              gap_left = 0;

   always @(posedge clock) begin
      req_data_type word;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) dir_answers.push_back(serve_request(cur_req));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || dir_requests.size() == 0 ||
                (dir_requests[0].wait_empty && dir_answers.size() != 0)) begin
               if (gap_left > 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               cur_req = dir_requests.pop_front();
               word = '0;
               word[REQ_OP_LSB +: OPCODE_W] = cur_req.opcode;
               word[REQ_KEY_LSB +: KEY_W] = cur_req.name_key;
               word[REQ_SEC_LSB +: SECIN_W] = cur_req.sector;
               req_tdata <= word;
               req_tvalid <= 1'b1;
               gap_left = cur_req.gap_after;
            end
         end
      end
   end

   // Long receiver hold-off so that the block fills up and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         cycle_no = 0;
         hold_left <= 0;
      end else begin
         cycle_no++;
         if (cycle_no == 20000 || cycle_no == 70000) hold_left <= 600;
         else if (hold_left > 0) hold_left <= hold_left - 1;
      end
   end

   // Result monitor and checker.
   int rx_stall = 0;

   always @(posedge clock) begin
      dir_answer_type want;
      logic [1:0]     got_status;
      logic [9:0]     got_sector;
      logic [5:0]     got_slot;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_status = rsp_tdata[RSP_ST_LSB +: STATUS_W];
            got_sector = rsp_tdata[RSP_SEC_LSB +: FSEC_W];
            got_slot = rsp_tdata[RSP_SLOT_LSB +: SLOT_W];
            if (dir_answers.size() == 0) begin
               flag_error("result transfer with no request outstanding");
            end else begin
               want = dir_answers.pop_front();
               if (got_status !== want.status)
                  flag_error($sformatf("result %0d: status %0d, expected %0d",
                                       replies_seen, got_status, want.status));
               if (got_sector !== want.found_sector)
                  flag_error($sformatf("result %0d: found_sector %0d, expected %0d",
                                       replies_seen, got_sector, want.found_sector));
               if (got_slot !== want.slot_index)
                  flag_error($sformatf("result %0d: slot_index %0d, expected %0d",
                                       replies_seen, got_slot, want.slot_index));
            end
            replies_seen++;
            // Every few hundred results, a run of results taken without stalls.
            rx_stall = (replies_seen % 256 < 48) ? 0 : $urandom_range(0, 10);
         end else if (rx_stall > 0) begin
            rx_stall--;
         end
         rsp_tready <= (rx_stall == 0) && (hold_left == 0);
      end
   end

   initial begin
      int  kind;
      int  span;
      int  roll;
      int  len;
      int  total;
      bit  quiet;
      bit  fresh;
      logic [1:0] op;

      // Distinct names of one to eight bytes, plus the empty name.
      name_pool[0] = '0;
      for (int p = 1; p < POOL_SIZE; p++) begin
         do begin
            len = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(1, 7);
            name_pool[p] = '0;
            for (int b = 0; b < len; b++) name_pool[p][8*b +: 8] = 8'($urandom_range(1, 255));
            fresh = 1'b1;
            for (int q = 0; q < p; q++) if (name_pool[q] == name_pool[p]) fresh = 1'b0;
         end while (!fresh);
      end

      // Directed part: empty table, extreme keys and sectors, names cut at
      // a zero byte, duplicates, the unused opcode and slot reuse.
      queue_request(OP_FIND,   64'h41, 10'd0, 0, 1'b0);
      queue_request(OP_REMOVE, 64'h41, 10'd0, 0, 1'b0);
      queue_request(OP_UNUSED, '1, '1, 2, 1'b0);
      queue_request(OP_ADD,    '1, 10'd1023, 0, 1'b0);
      queue_request(OP_FIND,   '1, 10'd0, 0, 1'b0);
      queue_request(OP_ADD,    '1, 10'd0, 3, 1'b0);
      queue_request(OP_ADD,    64'h0, 10'd0, 0, 1'b0);
      queue_request(OP_FIND,   64'hFFFF_FFFF_FFFF_FF00, 10'd7, 0, 1'b0);
      queue_request(OP_ADD,    64'hDEAD_BE00_0000_6261, 10'h2AA, 1, 1'b0);
      queue_request(OP_FIND,   64'h0000_0000_0000_6261, 10'd0, 0, 1'b0);
      queue_request(OP_ADD,    64'h0000_0000_0000_6261, 10'h155, 0, 1'b0);
      queue_request(OP_UNUSED, 64'h0000_0000_0000_6261, 10'd0, 5, 1'b0);
      queue_request(OP_REMOVE, 64'h1234_5600_0000_6261, 10'd1023, 0, 1'b0);
      queue_request(OP_FIND,   64'h0000_0000_0000_6261, 10'd0, 0, 1'b0);
      queue_request(OP_ADD,    64'h5555_5555_5555_5555, 10'h155, 0, 1'b0);
      queue_request(OP_ADD,    64'hAAAA_AAAA_AAAA_AAAA, 10'h2AA, 4, 1'b0);
      queue_request(OP_REMOVE, '1, 10'd0, 0, 1'b0);
      queue_request(OP_FIND,   '1, 10'd0, 0, 1'b0);
      queue_request(OP_ADD,    64'h0101_0101_0101_0101, 10'd1, 0, 1'b0);
      queue_request(OP_REMOVE, 64'h0, 10'd0, 0, 1'b0);
      queue_request(OP_UNUSED, 64'h0, 10'd1023, 0, 1'b0);
      queue_request(OP_FIND,   64'h5555_5555_5555_5555, 10'd0, 0, 1'b0);
      queue_request(OP_FIND,   64'hAAAA_AAAA_AAAA_AAAA, 10'd0, 0, 1'b0);

      // Random part in phases that fill, churn or drain the directory.
      // The first phase fills it well past its capacity.
      total = 0;
      while (total < RANDOM_ITEMS) begin
         kind = (total == 0) ? 0 : $urandom_range(0, 2);
         span = (total == 0) ? 200 : $urandom_range(60, 150);
         quiet = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < span; n++) begin
            roll = $urandom_range(0, 99);
            case (kind)
               0: op = (roll < 70) ? OP_ADD : (roll < 85) ? OP_FIND :
                       (roll < 97) ? OP_REMOVE : OP_UNUSED;
               1: op = (roll < 35) ? OP_ADD : (roll < 65) ? OP_FIND :
                       (roll < 97) ? OP_REMOVE : OP_UNUSED;
               default: op = (roll < 15) ? OP_ADD : (roll < 40) ? OP_FIND :
                             (roll < 97) ? OP_REMOVE : OP_UNUSED;
            endcase
            queue_request(op, pick_name(), 10'($urandom_range(0, 1023)),
                          quiet ? 0 : $urandom_range(0, 10),
                          n == 0 && (total == 0 || $urandom_range(0, 2) == 0));
            total++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (dir_requests.size() != 0 || req_tvalid) @(posedge clock);
      while (dir_answers.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (faults == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/dnt_pkg.sv
hw/rtl/directory_name_table_core.sv
hw/rtl/dnt_checker.sv
tb/sv/directory_name_table_core_test.sv
